@@ src/clock_page_replacement_assert.svh @@
// Assertion macros shared by the page replacement RTL.
`ifndef CLOCK_PAGE_REPLACEMENT_ASSERT_SVH
`define CLOCK_PAGE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define CPR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page replacement check failed");

// Next-cycle implication, held off during reset.
`define CPR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page replacement check failed");

`endif

@@ src/cpr_pkg.sv @@
package cpr_pkg;

  localparam int PAGE_W = 16;
  localparam int ADDR_W = 16;
  localparam int SLOT_W = 2;
  localparam int COUNT_W = 16;

  localparam logic [COUNT_W-1:0] FAULT_MAX = 16'hFFFF;

  // Item mode codes
  localparam logic MODE_ACCESS = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [PAGE_W-1:0] page_number;
    logic [ADDR_W-1:0] storage_address;
    logic              in_physical;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               fault;
    logic [SLOT_W-1:0]  slot;
    logic               evicted;
    logic [PAGE_W-1:0]  evicted_page;
    logic [ADDR_W-1:0]  evicted_address;
    logic               evicted_in_physical;
    logic [COUNT_W-1:0] fault_count;
  } rsp_t;

  // One frame as held in the frame RAM
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [ADDR_W-1:0] address;
    logic              physical;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_EVICT,
    ST_DONE
  } state_t;

endpackage

@@ src/cpr_ram.sv @@
module cpr_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/clock_page_replacement.sv @@
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_stall   cpr_pkg::req_t (mode, page, address, residence)
// rsp      out        rsp_valid / rsp_stall   cpr_pkg::rsp_t (hit, fault, slot, victim, count)
//
// An access scans the frame RAM one frame per cycle, ended early by a hit. A miss with no
// free frame then sweeps the hand through the same RAM read port, and in the evict state
// reads out the victim and writes the page. An item is accepted in the idle state and its
// result loaded into the result register in the done state; a flush goes from idle to done.
// Synchronous reset empties the table, zeroes the hand and the fault count.
// req_stall is high while an item is in work; a stalled result holds the block in its
// final state until the result register frees up.
`include "clock_page_replacement_assert.svh"

module clock_page_replacement #(
  parameter int FRAMES = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cpr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cpr_pkg::rsp_t rsp
);

  localparam int FW = $clog2(FRAMES);
  localparam logic [FW-1:0] LAST_FRAME = FW'(FRAMES - 1);
  localparam logic [FW:0] SCAN_END = (FW + 1)'(FRAMES);

  cpr_pkg::state_t state, state_next;

  cpr_pkg::req_t   item;
  cpr_pkg::rsp_t   res;
  logic [FW:0]     cnt;
  logic            probe_valid;
  logic [FW-1:0]   probe_idx;
  logic            free_found;
  logic [FW-1:0]   free_idx;
  logic [FRAMES-1:0] used;
  logic [FRAMES-1:0] refb;
  logic [FW-1:0]   hand;
  logic [cpr_pkg::COUNT_W-1:0] faults;

  logic            accept;
  logic            hit_now;
  logic            miss_now;
  logic            free_now;
  logic            have_free;
  logic [FW-1:0]   fill_idx;
  logic [FW-1:0]   hand_inc;
  logic [cpr_pkg::COUNT_W-1:0] faults_inc;
  logic            rsp_free;

  logic            ram_we;
  logic [FW-1:0]   ram_waddr;
  logic [FW-1:0]   ram_raddr;
  cpr_pkg::entry_t ram_wdata;
  cpr_pkg::entry_t ram_rdata;

  cpr_ram #(
    .WIDTH ($bits(cpr_pkg::entry_t)),
    .DEPTH (FRAMES)
  ) u_frames (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Compare the frame read last cycle against the requested page
  assign accept     = req_valid && !req_stall;
  assign hit_now    = (state == cpr_pkg::ST_SCAN) && probe_valid && used[probe_idx] &&
                      (ram_rdata.page == item.page_number);
  assign miss_now   = (state == cpr_pkg::ST_SCAN) && probe_valid &&
                      (probe_idx == LAST_FRAME) && !hit_now;
  assign free_now   = (state == cpr_pkg::ST_SCAN) && probe_valid && !used[probe_idx];
  assign have_free  = free_found || free_now;
  assign fill_idx   = free_found ? free_idx : probe_idx;
  assign hand_inc   = (hand == LAST_FRAME) ? '0 : hand + FW'(1);
  assign faults_inc = (faults == cpr_pkg::FAULT_MAX) ? faults
                                                     : faults + cpr_pkg::COUNT_W'(1);
  assign rsp_free   = !rsp_valid || !rsp_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cpr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (req.mode == cpr_pkg::MODE_FLUSH) ? cpr_pkg::ST_DONE
                                                         : cpr_pkg::ST_SCAN;
        end
      end
      cpr_pkg::ST_SCAN: begin
        if (hit_now) begin
          state_next = cpr_pkg::ST_DONE;
        end else if (miss_now) begin
          state_next = have_free ? cpr_pkg::ST_DONE : cpr_pkg::ST_SWEEP;
        end
      end
      cpr_pkg::ST_SWEEP: begin
        if (!refb[hand]) begin
          state_next = cpr_pkg::ST_EVICT;
        end
      end
      cpr_pkg::ST_EVICT: begin
        state_next = cpr_pkg::ST_DONE;
      end
      cpr_pkg::ST_DONE: begin
        if (rsp_free) begin
          state_next = cpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cpr_pkg::ST_IDLE;
      end
    endcase
  end

  // Handshake and frame RAM controls
  always_comb begin
    req_stall = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    ram_wdata.page     = item.page_number;
    ram_wdata.address  = item.storage_address;
    ram_wdata.physical = item.in_physical;
    case (state)
      cpr_pkg::ST_IDLE: begin
        req_stall = 1'b0;
      end
      cpr_pkg::ST_SCAN: begin
        ram_raddr = cnt[FW-1:0];
        if (miss_now && have_free) begin
          ram_we    = 1'b1;
          ram_waddr = fill_idx;
        end
      end
      cpr_pkg::ST_SWEEP: begin
        ram_raddr = hand;
      end
      cpr_pkg::ST_EVICT: begin
        ram_we    = 1'b1;
        ram_waddr = hand;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // Sequencer registers, table bits and result staging
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cpr_pkg::ST_IDLE;
      used        <= '0;
      refb        <= '0;
      hand        <= '0;
      faults      <= '0;
      probe_valid <= 1'b0;
      free_found  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      probe_valid <= (state == cpr_pkg::ST_SCAN) && (cnt < SCAN_END);

      case (state)
        cpr_pkg::ST_IDLE: begin
          if (accept) begin
            item       <= req;
            cnt        <= '0;
            free_found <= 1'b0;
            res        <= '0;
            if (req.mode == cpr_pkg::MODE_FLUSH) begin
              used   <= '0;
              refb   <= '0;
              hand   <= '0;
              faults <= '0;
            end
          end
        end
        cpr_pkg::ST_SCAN: begin
          // Advance the read pointer, remember the lowest free frame
          if (cnt < SCAN_END) begin
            cnt       <= cnt + (FW + 1)'(1);
            probe_idx <= cnt[FW-1:0];
          end
          if (free_now && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= probe_idx;
          end
          if (hit_now) begin
            refb[probe_idx] <= 1'b1;
            res.hit         <= 1'b1;
            res.slot        <= cpr_pkg::SLOT_W'(probe_idx);
            res.fault_count <= faults;
          end else if (miss_now) begin
            faults          <= faults_inc;
            res.fault       <= 1'b1;
            res.fault_count <= faults_inc;
            if (have_free) begin
              used[fill_idx] <= 1'b1;
              refb[fill_idx] <= 1'b1;
              res.slot       <= cpr_pkg::SLOT_W'(fill_idx);
            end
          end
        end
        cpr_pkg::ST_SWEEP: begin
          // Give referenced frames a second chance
          if (refb[hand]) begin
            refb[hand] <= 1'b0;
            hand       <= hand_inc;
          end
        end
        cpr_pkg::ST_EVICT: begin
          refb[hand]              <= 1'b1;
          hand                    <= hand_inc;
          res.slot                <= cpr_pkg::SLOT_W'(hand);
          res.evicted             <= 1'b1;
          res.evicted_page        <= ram_rdata.page;
          res.evicted_address     <= ram_rdata.address;
          res.evicted_in_physical <= ram_rdata.physical;
        end
        default: begin
        end
      endcase

      // Load the staged result when the register frees up, else drop a taken one
      if ((state == cpr_pkg::ST_DONE) && rsp_free) begin
        rsp_valid <= 1'b1;
        rsp       <= res;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `CPR_ASSERT_NXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)
  `CPR_ASSERT_IMP(a_hand_in_range, clk, rst, 1'b1, hand <= LAST_FRAME)
  `CPR_ASSERT_IMP(a_hit_not_fault, clk, rst, rsp_valid, !(rsp.hit && rsp.fault))
  `CPR_ASSERT_IMP(a_evict_is_fault, clk, rst, rsp_valid && rsp.evicted, rsp.fault)
  `CPR_ASSERT_IMP(a_evict_when_full, clk, rst, state == cpr_pkg::ST_SWEEP, &used)

endmodule
